/* src/huffman_header_checker_macros.svh */
// Assertion macros for the header checker.
// Included by the top level; the macros expect clk and arst_n in scope.
`ifndef HUFFMAN_HEADER_CHECKER_MACROS_SVH
`define HUFFMAN_HEADER_CHECKER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define HHC_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("header checker assertion failed");

// Next-cycle implication.
`define HHC_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("header checker assertion failed");

`endif

/* src/hhc_pkg.sv */
// Shared types and constants for the header checker.
// Used by the front, the queue, the back and the top level; no dependencies.
`timescale 1ns / 1ps

package hhc_pkg;

	localparam int MAX_CODE_LENGTH_DEF = 15;
	localparam int SYMBOL_COUNT_DEF    = 256;
	localparam int QUEUE_DEPTH         = 2;
	localparam int KRAFT_W             = 24;
	localparam int CFG_INDEX_W         = 2;
	localparam int CFG_DATA_W          = 32;

	localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_WORD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_KNOWN_MASK = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_RAW_MASK   = 2'd2;

	localparam logic [31:0] MAGIC_RESET      = 32'd1935767411;
	localparam logic [7:0]  KNOWN_MASK_RESET = 8'd1;
	localparam logic [7:0]  RAW_MASK_RESET   = 8'd1;

	localparam logic KIND_ENTRY   = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_SHORT      = 3'd1,
		ERR_MAGIC      = 3'd2,
		ERR_FLAG       = 3'd3,
		ERR_LENGTHS    = 3'd4,
		ERR_RAW_CODES  = 3'd5,
		ERR_NO_CODES   = 3'd6
	} err_t;

	// What one input item asks the back part to deliver.
	typedef struct packed {
		logic        has_entry;
		logic [7:0]  entry_index;
		logic [7:0]  entry_length;
		logic        has_verdict;
		logic        ok;
		err_t        err;
		logic [7:0]  flags;
		logic [63:0] olen;
		logic [31:0] crc;
	} job_t;

endpackage

/* src/hhc_front.sv */
// Front part of the header checker: accepts bytes, tracks the header parse
// and turns each item into a job for the back part. Depends on hhc_pkg.
`timescale 1ns / 1ps

module hhc_front #(
	parameter int MAX_CODE_LENGTH = hhc_pkg::MAX_CODE_LENGTH_DEF,
	parameter int SYMBOL_COUNT    = hhc_pkg::SYMBOL_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [hhc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [hhc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	input  logic                             queue_full,
	input  logic [7:0]                       byte_value,
	input  logic                             end_of_data,
	output logic                             push,
	output hhc_pkg::job_t                    job
);

	localparam int HDR   = 17 + SYMBOL_COUNT;
	localparam int POS_W = $clog2(HDR + 1);
	localparam int KW    = hhc_pkg::KRAFT_W;
	localparam logic [KW-1:0] KRAFT_LIMIT = KW'(1) << MAX_CODE_LENGTH;

	logic [31:0]      magic_q;
	logic [7:0]       known_q;
	logic [7:0]       raw_q;

	logic [POS_W-1:0] pos_q, pos_n;
	logic             mm_q, mm_n;
	logic [7:0]       flag_q, flag_n;
	logic [63:0]      len_q, len_n;
	logic [31:0]      crc_q, crc_n;
	logic [KW-1:0]    kraft_q, kraft_n;
	logic             long_q, long_n;
	logic             any_q, any_n;
	logic             vg_q, vg_n;

	logic             take;
	logic [POS_W-1:0] rel;
	logic [4:0]       shamt;
	logic [KW:0]      ksum;
	hhc_pkg::err_t    verdict;

	assign take = in_valid && !queue_full;
	assign push = take && (job.has_entry || job.has_verdict);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= hhc_pkg::MAGIC_RESET;
			known_q <= hhc_pkg::KNOWN_MASK_RESET;
			raw_q   <= hhc_pkg::RAW_MASK_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				hhc_pkg::CFG_MAGIC_WORD: magic_q <= cfg_data;
				hhc_pkg::CFG_KNOWN_MASK: known_q <= cfg_data[7:0];
				hhc_pkg::CFG_RAW_MASK:   raw_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		pos_n   = pos_q;
		mm_n    = mm_q;
		flag_n  = flag_q;
		len_n   = len_q;
		crc_n   = crc_q;
		kraft_n = kraft_q;
		long_n  = long_q;
		any_n   = any_q;
		vg_n    = vg_q;
		job     = '0;
		rel     = '0;
		shamt   = 5'(8'(MAX_CODE_LENGTH) - byte_value);
		ksum    = {1'b0, kraft_q} + {1'b0, KW'(1) << shamt};
		verdict = hhc_pkg::ERR_NONE;

		if (pos_q < POS_W'(HDR)) begin
			if (pos_q < POS_W'(4)) begin
				if (magic_q[{pos_q[1:0], 3'b000} +: 8] != byte_value) begin
					mm_n = 1'b0;
				end
			end else if (pos_q == POS_W'(4)) begin
				flag_n = byte_value;
			end else if (pos_q < POS_W'(13)) begin
				// Each slot is written once per buffer, so a plain write equals the OR.
				rel = pos_q - POS_W'(5);
				len_n[{rel[2:0], 3'b000} +: 8] = byte_value;
			end else if (pos_q < POS_W'(17)) begin
				rel = pos_q - POS_W'(13);
				crc_n[{rel[1:0], 3'b000} +: 8] = byte_value;
			end else begin
				rel = pos_q - POS_W'(17);
				job.has_entry    = 1'b1;
				job.entry_index  = 8'(rel);
				job.entry_length = byte_value;
				if (byte_value != 8'd0) begin
					any_n = 1'b1;
					if (byte_value > 8'(MAX_CODE_LENGTH)) begin
						long_n = 1'b1;
					end else begin
						kraft_n = ksum[KW] ? '1 : ksum[KW-1:0];
					end
				end
			end
			pos_n = pos_q + POS_W'(1);

			if (pos_n == POS_W'(HDR)) begin
				if (!mm_n) begin
					verdict = hhc_pkg::ERR_MAGIC;
				end else if ((flag_n & ~known_q) != 8'd0) begin
					verdict = hhc_pkg::ERR_FLAG;
				end else if (long_n || kraft_n > KRAFT_LIMIT) begin
					verdict = hhc_pkg::ERR_LENGTHS;
				end else if ((flag_n & raw_q) != 8'd0) begin
					verdict = any_n ? hhc_pkg::ERR_RAW_CODES : hhc_pkg::ERR_NONE;
				end else if (len_n != 64'd0 && !any_n) begin
					verdict = hhc_pkg::ERR_NO_CODES;
				end
				job.has_verdict = 1'b1;
				job.ok          = (verdict == hhc_pkg::ERR_NONE);
				job.err         = verdict;
				job.flags       = flag_n;
				job.olen        = len_n;
				job.crc         = crc_n;
				vg_n            = 1'b1;
			end
		end

		if (end_of_data) begin
			if (!vg_n) begin
				job.has_verdict = 1'b1;
				job.ok          = 1'b0;
				job.err         = hhc_pkg::ERR_SHORT;
				job.flags       = '0;
				job.olen        = '0;
				job.crc         = '0;
			end
			pos_n   = '0;
			mm_n    = 1'b1;
			flag_n  = '0;
			len_n   = '0;
			crc_n   = '0;
			kraft_n = '0;
			long_n  = 1'b0;
			any_n   = 1'b0;
			vg_n    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			mm_q    <= 1'b1;
			flag_q  <= '0;
			len_q   <= '0;
			crc_q   <= '0;
			kraft_q <= '0;
			long_q  <= 1'b0;
			any_q   <= 1'b0;
			vg_q    <= 1'b0;
		end else if (take) begin
			pos_q   <= pos_n;
			mm_q    <= mm_n;
			flag_q  <= flag_n;
			len_q   <= len_n;
			crc_q   <= crc_n;
			kraft_q <= kraft_n;
			long_q  <= long_n;
			any_q   <= any_n;
			vg_q    <= vg_n;
		end
	end

endmodule

/* src/hhc_queue.sv */
// Short job queue between the front and back parts of the header checker.
// Holds hhc_pkg::job_t entries in flip-flops; depends on hhc_pkg.
`timescale 1ns / 1ps

module hhc_queue #(
	parameter int DEPTH = hhc_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hhc_pkg::job_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output hhc_pkg::job_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	hhc_pkg::job_t  slot_q [DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  count_q;
	logic           do_push, do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* src/hhc_back.sv */
// Back part of the header checker: takes jobs from the queue and delivers
// their entry and verdict items through an output register. Depends on hhc_pkg.
`timescale 1ns / 1ps

module hhc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  hhc_pkg::job_t job,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          result_kind,
	output logic [7:0]    entry_index,
	output logic [7:0]    entry_length,
	output logic          header_ok,
	output logic [2:0]    error_code,
	output logic [7:0]    flags_value,
	output logic [63:0]   original_length,
	output logic [31:0]   stored_crc,
	output logic          last_of_run
);

	logic          valid_q;
	logic          phase_q, phase_n;
	logic          load;
	logic          kind_n, ok_n, last_n;
	logic [7:0]    idx_n, len_n, flags_n;
	logic [2:0]    err_n;
	logic [63:0]   olen_n;
	logic [31:0]   crc_n;

	logic          kind_q, ok_q, last_q;
	logic [7:0]    idx_q, len_q, flags_q;
	logic [2:0]    err_q;
	logic [63:0]   olen_q;
	logic [31:0]   crc_q;

	assign load = !valid_q || !out_stall;

	// phase_q is set once the entry of a two-item job has gone out.
	always_comb begin
		pop     = 1'b0;
		phase_n = phase_q;
		kind_n  = hhc_pkg::KIND_ENTRY;
		idx_n   = '0;
		len_n   = '0;
		ok_n    = 1'b0;
		err_n   = '0;
		flags_n = '0;
		olen_n  = '0;
		crc_n   = '0;
		last_n  = 1'b1;
		if (job_valid && load) begin
			if (job.has_entry && !phase_q) begin
				idx_n  = job.entry_index;
				len_n  = job.entry_length;
				last_n = !job.has_verdict;
				if (job.has_verdict) begin
					phase_n = 1'b1;
				end else begin
					pop = 1'b1;
				end
			end else begin
				kind_n  = hhc_pkg::KIND_VERDICT;
				ok_n    = job.ok;
				err_n   = job.err;
				flags_n = job.flags;
				olen_n  = job.olen;
				crc_n   = job.crc;
				pop     = 1'b1;
				phase_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			phase_q <= phase_n;
			if (load) begin
				valid_q <= job_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && job_valid) begin
			kind_q  <= kind_n;
			idx_q   <= idx_n;
			len_q   <= len_n;
			ok_q    <= ok_n;
			err_q   <= err_n;
			flags_q <= flags_n;
			olen_q  <= olen_n;
			crc_q   <= crc_n;
			last_q  <= last_n;
		end
	end

	assign out_valid       = valid_q;
	assign result_kind     = kind_q;
	assign entry_index     = idx_q;
	assign entry_length    = len_q;
	assign header_ok       = ok_q;
	assign error_code      = err_q;
	assign flags_value     = flags_q;
	assign original_length = olen_q;
	assign stored_crc      = crc_q;
	assign last_of_run     = last_q;

endmodule

/* src/huffman_header_checker.sv */
// Header checker: takes one header byte per cycle unless stalled and forwards
// each code-length byte plus a final verdict. Depends on hhc_pkg, hhc_front, hhc_queue, hhc_back.
//
// The block accepts one byte every clock cycle while the two-entry job queue
// between its front and back parts has room. The front parses the 17 fixed
// bytes and 256 code-length bytes, and the back delivers one item per cycle
// from its output register while out_stall is low. Most bytes produce zero or
// one item; the last header byte, or an end mark arriving mid-header after a
// length byte, produces two, and the queue absorbs the extra item. Configuration
// writes take effect on the next edge.
`timescale 1ns / 1ps
`include "huffman_header_checker_macros.svh"

module huffman_header_checker #(
	parameter int MAX_CODE_LENGTH = hhc_pkg::MAX_CODE_LENGTH_DEF,
	parameter int SYMBOL_COUNT    = hhc_pkg::SYMBOL_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [hhc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [hhc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       byte_value,
	input  logic                             end_of_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             result_kind,
	output logic [7:0]                       entry_index,
	output logic [7:0]                       entry_length,
	output logic                             header_ok,
	output logic [2:0]                       error_code,
	output logic [7:0]                       flags_value,
	output logic [63:0]                      original_length,
	output logic [31:0]                      stored_crc,
	output logic                             last_of_run
);

	logic          push, pop, full, not_empty;
	hhc_pkg::job_t new_job, head_job;

	assign in_stall = full;

	hhc_front #(
		.MAX_CODE_LENGTH (MAX_CODE_LENGTH),
		.SYMBOL_COUNT    (SYMBOL_COUNT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.queue_full  (full),
		.byte_value  (byte_value),
		.end_of_data (end_of_data),
		.push        (push),
		.job         (new_job)
	);

	hhc_queue #(
		.DEPTH (hhc_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (new_job),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head_job)
	);

	hhc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.job_valid       (not_empty),
		.job             (head_job),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.result_kind     (result_kind),
		.entry_index     (entry_index),
		.entry_length    (entry_length),
		.header_ok       (header_ok),
		.error_code      (error_code),
		.flags_value     (flags_value),
		.original_length (original_length),
		.stored_crc      (stored_crc),
		.last_of_run     (last_of_run)
	);

	`HHC_ASSERT_NOW(a_verdict_is_last, out_valid && result_kind == hhc_pkg::KIND_VERDICT, last_of_run)
	`HHC_ASSERT_NOW(a_ok_matches_code, out_valid && result_kind == hhc_pkg::KIND_VERDICT, header_ok == (error_code == hhc_pkg::ERR_NONE))
	`HHC_ASSERT_NEXT(a_entry_then_verdict, out_valid && !out_stall && result_kind == hhc_pkg::KIND_ENTRY && !last_of_run, out_valid && result_kind == hhc_pkg::KIND_VERDICT)

endmodule

/* test/huffman_header_checker_test.sv */
// Self-checking testbench for huffman_header_checker: streams header buffers through
// the byte port under random stalls and compares every result with a built-in predictor.
// Depends on hhc_pkg and the huffman_header_checker RTL.
`timescale 1ns / 1ps

module huffman_header_checker_test;
	import hhc_pkg::*;

	localparam int MAX_LEN = MAX_CODE_LENGTH_DEF;
	localparam int HEADER_LEN = 17 + SYMBOL_COUNT_DEF;
	localparam logic [9:0] HDR_LAST = 10'(HEADER_LEN - 1);
	localparam int TOTAL_ITEMS = 1250;

	typedef enum logic [3:0] {
		LP_ZERO,
		LP_SINGLE,
		LP_LAST15,
		LP_FULL_TREE,
		LP_OVERSUB,
		LP_TOO_LONG,
		LP_ALL_FF,
		LP_SPARSE,
		LP_ANY
	} len_pattern_t;

	// One header buffer: register setting, header contents, and the byte that carries
	// the end mark. The wanted error code is only used by the directed table.
	typedef struct packed {
		logic [31:0]  cfg_magic;
		logic [7:0]   cfg_known;
		logic [7:0]   cfg_raw;
		logic [31:0]  hdr_magic;
		logic [7:0]   flags;
		logic [63:0]  olen;
		logic [31:0]  crc;
		len_pattern_t pattern;
		logic [9:0]   cut;
		err_t         want;
	} header_case_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  sym;
		logic [7:0]  code_len;
		logic        ok;
		err_t        err;
		logic [7:0]  flags;
		logic [63:0] olen_val;
		logic [31:0] crc;
		logic        last;
	} hdr_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_MAGIC_WORD;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] byte_value = 8'd0;
	logic end_of_data = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic result_kind;
	logic [7:0] entry_index;
	logic [7:0] entry_length;
	logic header_ok;
	logic [2:0] error_code;
	logic [7:0] flags_value;
	logic [63:0] original_length;
	logic [31:0] stored_crc;
	logic last_of_run;

	// Predictor copy of the registers and the parse state.
	logic [31:0] exp_magic = MAGIC_RESET;
	logic [7:0] allowed_flags = KNOWN_MASK_RESET;
	logic [7:0] raw_flags = RAW_MASK_RESET;
	int hdr_pos = 0;
	logic magic_ok = 1'b1;
	logic [7:0] flag_reg = '0;
	logic [63:0] olen_acc = '0;
	logic [31:0] crc_acc = '0;
	logic [23:0] kraft_acc = '0;
	logic overlong = 1'b0;
	logic codes_seen = 1'b0;
	logic verdict_done = 1'b0;

	hdr_result_t expected_results[$];
	hdr_result_t typed_verdict = '0;
	bit typed_active = 1'b0;
	logic [7:0] buffer_bytes[$];

	int sender_idle_pct = 11;
	int receiver_stall_pct = 45;
	int items_sent = 0;
	int items_accepted = 0;
	int results_checked = 0;
	int buffers_sent = 0;
	int mismatch_count = 0;
	int verdict_tally[7] = '{default: 0};

	header_case_t directed_cases[6] = '{
		'{MAGIC_RESET, KNOWN_MASK_RESET, RAW_MASK_RESET, MAGIC_RESET, 8'h00, '1, '1,
			LP_FULL_TREE, HDR_LAST + 10'd3, ERR_NONE},
		'{MAGIC_RESET, KNOWN_MASK_RESET, RAW_MASK_RESET, MAGIC_RESET, 8'h01, 64'd5, 32'd0,
			LP_SINGLE, HDR_LAST, ERR_RAW_CODES},
		'{MAGIC_RESET, KNOWN_MASK_RESET, RAW_MASK_RESET, MAGIC_RESET, 8'h01, 64'd0, 32'd0,
			LP_TOO_LONG, HDR_LAST, ERR_LENGTHS},
		'{MAGIC_RESET, KNOWN_MASK_RESET, RAW_MASK_RESET, MAGIC_RESET, 8'h01, 64'd0, 32'd0,
			LP_ZERO, 10'd0, ERR_SHORT},
		'{MAGIC_RESET, KNOWN_MASK_RESET, RAW_MASK_RESET, MAGIC_RESET, 8'h01, 64'd0, 32'd0,
			LP_ZERO, 10'd4, ERR_SHORT},
		'{MAGIC_RESET, KNOWN_MASK_RESET, RAW_MASK_RESET, MAGIC_RESET, 8'h00, 64'd0, 32'd0,
			LP_SINGLE, 10'd17, ERR_SHORT}
	};

	huffman_header_checker i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_value(byte_value),
		.end_of_data(end_of_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.entry_index(entry_index),
		.entry_length(entry_length),
		.header_ok(header_ok),
		.error_code(error_code),
		.flags_value(flags_value),
		.original_length(original_length),
		.stored_crc(stored_crc),
		.last_of_run(last_of_run)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void clear_parse();
		hdr_pos = 0;
		magic_ok = 1'b1;
		flag_reg = '0;
		olen_acc = '0;
		crc_acc = '0;
		kraft_acc = '0;
		overlong = 1'b0;
		codes_seen = 1'b0;
		verdict_done = 1'b0;
	endfunction

	function automatic err_t header_error();
		if (!magic_ok) return ERR_MAGIC;
		if ((flag_reg & ~allowed_flags) != 8'd0) return ERR_FLAG;
		if (overlong || kraft_acc > (24'd1 << MAX_LEN)) return ERR_LENGTHS;
		if ((flag_reg & raw_flags) != 8'd0) begin
			if (codes_seen) return ERR_RAW_CODES;
		end else if (olen_acc != 64'd0 && !codes_seen) begin
			return ERR_NO_CODES;
		end
		return ERR_NONE;
	endfunction

	// Advances the parse by one accepted item and queues the results it causes.
	function automatic void predict_byte(logic [7:0] b, logic eod);
		hdr_result_t entry;
		hdr_result_t verdict;
		logic [24:0] kraft_next;
		bit have_entry;
		bit have_verdict;
		entry = '0;
		verdict = '0;
		have_entry = 1'b0;
		have_verdict = 1'b0;
		if (hdr_pos < HEADER_LEN) begin
			if (hdr_pos < 4) begin
				if (exp_magic[8*hdr_pos +: 8] != b) magic_ok = 1'b0;
			end else if (hdr_pos == 4) begin
				flag_reg = b;
			end else if (hdr_pos < 13) begin
				olen_acc[8*(hdr_pos-5) +: 8] = b;
			end else if (hdr_pos < 17) begin
				crc_acc[8*(hdr_pos-13) +: 8] = b;
			end else begin
				if (b != 8'd0) begin
					codes_seen = 1'b1;
					if (b > MAX_LEN) begin
						overlong = 1'b1;
					end else begin
						kraft_next = {1'b0, kraft_acc} + (25'd1 << (MAX_LEN - b));
						kraft_acc = kraft_next[24] ? '1 : kraft_next[23:0];
					end
				end
				entry.kind = KIND_ENTRY;
				entry.sym = 8'(hdr_pos - 17);
				entry.code_len = b;
				have_entry = 1'b1;
			end
			hdr_pos++;
			if (hdr_pos == HEADER_LEN) begin
				verdict.kind = KIND_VERDICT;
				verdict.err = header_error();
				verdict.ok = (verdict.err == ERR_NONE);
				verdict.flags = flag_reg;
				verdict.olen_val = olen_acc;
				verdict.crc = crc_acc;
				have_verdict = 1'b1;
				verdict_done = 1'b1;
			end
		end
		if (eod) begin
			if (!verdict_done) begin
				verdict = '0;
				verdict.kind = KIND_VERDICT;
				verdict.err = ERR_SHORT;
				have_verdict = 1'b1;
			end
			clear_parse();
		end
		// In the directed table the verdict is typed in by hand instead.
		if (have_verdict && typed_active) verdict = typed_verdict;
		if (have_verdict) verdict.last = 1'b1;
		else entry.last = 1'b1;
		if (have_entry) expected_results.insert(expected_results.size(), entry);
		if (have_verdict) expected_results.insert(expected_results.size(), verdict);
	endfunction

	function automatic void field_check(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	function automatic void check_result();
		hdr_result_t want;
		if (expected_results.size() == 0) begin
			$display("%0t: result with none expected, expected nothing, actual kind %0d",
				$time, result_kind);
			mismatch_count++;
			return;
		end
		want = expected_results.pop_front();
		field_check("result_kind", 64'(want.kind), 64'(result_kind));
		field_check("entry_index", 64'(want.sym), 64'(entry_index));
		field_check("entry_length", 64'(want.code_len), 64'(entry_length));
		field_check("header_ok", 64'(want.ok), 64'(header_ok));
		field_check("error_code", 64'(want.err), 64'(error_code));
		field_check("flags_value", 64'(want.flags), 64'(flags_value));
		field_check("original_length", want.olen_val, original_length);
		field_check("stored_crc", 64'(want.crc), 64'(stored_crc));
		field_check("last_of_run", 64'(want.last), 64'(last_of_run));
		if (want.kind == KIND_VERDICT) verdict_tally[int'(want.err)]++;
		results_checked++;
	endfunction

	// Prediction runs before the check so that a same-edge result would still line up.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_byte(byte_value, end_of_data);
				items_accepted++;
			end
			if (out_valid && !out_stall) check_result();
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	function automatic logic [7:0] code_length_for(len_pattern_t p, int sym);
		case (p)
			LP_ZERO: return 8'd0;
			LP_SINGLE: return (sym == 0) ? 8'd1 : 8'd0;
			LP_LAST15: return (sym == SYMBOL_COUNT_DEF - 1) ? 8'(MAX_LEN) : 8'd0;
			// 256 codes of length 8 fill the code space exactly; length 7 overfills it.
			LP_FULL_TREE: return 8'd8;
			LP_OVERSUB: return 8'd7;
			LP_TOO_LONG: return (sym == 0) ? 8'd1 : (sym == 100) ? 8'(MAX_LEN + 1) : 8'd0;
			LP_ALL_FF: return 8'hFF;
			LP_SPARSE: begin
				if ($urandom_range(3) != 0) return 8'd0;
				if ($urandom_range(19) == 0) return 8'($urandom_range(6, 1));
				return 8'($urandom_range(MAX_LEN, 7));
			end
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic void build_buffer(header_case_t c);
		buffer_bytes.delete();
		for (int p = 0; p <= int'(c.cut); p++) begin
			if (p < 4) buffer_bytes.insert(buffer_bytes.size(), c.hdr_magic[8*p +: 8]);
			else if (p == 4) buffer_bytes.insert(buffer_bytes.size(), c.flags);
			else if (p < 13) buffer_bytes.insert(buffer_bytes.size(), c.olen[8*(p-5) +: 8]);
			else if (p < 17) buffer_bytes.insert(buffer_bytes.size(), c.crc[8*(p-13) +: 8]);
			else if (p < HEADER_LEN)
				buffer_bytes.insert(buffer_bytes.size(), code_length_for(c.pattern, p - 17));
			else buffer_bytes.insert(buffer_bytes.size(), 8'($urandom_range(255)));
		end
	endfunction

	function automatic header_case_t random_case();
		header_case_t c;
		int pick;
		int w;
		c = '0;
		pick = $urandom_range(99);
		w = $urandom_range(99);
		c.hdr_magic = ($urandom_range(9) == 0) ? exp_magic ^ (32'h1 << $urandom_range(31))
			: exp_magic;
		c.flags = ($urandom_range(9) < 7) ? (8'($urandom) & allowed_flags) : 8'($urandom);
		c.olen = ($urandom_range(3) == 0) ? 64'd0 : {$urandom, $urandom};
		c.crc = $urandom;
		if (w < 45) c.pattern = LP_SPARSE;
		else if (w < 57) c.pattern = LP_ANY;
		else if (w < 67) c.pattern = LP_ZERO;
		else if (w < 77) c.pattern = LP_SINGLE;
		else if (w < 82) c.pattern = LP_LAST15;
		else if (w < 87) c.pattern = LP_FULL_TREE;
		else if (w < 92) c.pattern = LP_OVERSUB;
		else if (w < 97) c.pattern = LP_TOO_LONG;
		else c.pattern = LP_ALL_FF;
		// Raw headers mostly come without codes so that they can pass.
		if ((c.flags & raw_flags) != 8'd0 && $urandom_range(4) != 0) c.pattern = LP_ZERO;
		if (pick < 65) begin
			c.cut = HDR_LAST;
		end else if (pick < 75) begin
			c.cut = HDR_LAST + 10'($urandom_range(4, 1));
		end else if (pick < 90) begin
			c.cut = 10'($urandom_range(HEADER_LEN - 2));
		end else begin
			c.hdr_magic = $urandom;
			c.flags = 8'($urandom);
			c.pattern = LP_ANY;
			c.cut = 10'($urandom_range(19));
		end
		return c;
	endfunction

	task automatic send_buffer();
		for (int i = 0; i < buffer_bytes.size(); i++) begin
			while ($urandom_range(99) < sender_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			byte_value <= buffer_bytes[i];
			end_of_data <= (i == buffer_bytes.size() - 1);
			@(posedge clk);
			while (in_stall) @(posedge clk);
			items_sent++;
		end
		buffers_sent++;
	endtask

	// Holds the sender off until every queued result has come out, then lets the
	// pipeline settle in case the last item was a trailing byte with no result.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_config(logic [31:0] magic, logic [7:0] known, logic [7:0] raw);
		cfg_write <= 1'b1;
		cfg_index <= CFG_MAGIC_WORD;
		cfg_data <= magic;
		@(posedge clk);
		cfg_index <= CFG_KNOWN_MASK;
		cfg_data <= {24'd0, known};
		@(posedge clk);
		cfg_index <= CFG_RAW_MASK;
		cfg_data <= {24'd0, raw};
		@(posedge clk);
		cfg_write <= 1'b0;
		exp_magic = magic;
		allowed_flags = known;
		raw_flags = raw;
	endtask

	initial begin
		header_case_t c;
		int phase_end;
		int random_budget;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_cases[r]) begin
			c = directed_cases[r];
			drain_results();
			write_config(c.cfg_magic, c.cfg_known, c.cfg_raw);
			typed_verdict = '0;
			typed_verdict.kind = KIND_VERDICT;
			typed_verdict.err = c.want;
			if (c.want != ERR_SHORT) begin
				typed_verdict.ok = (c.want == ERR_NONE);
				typed_verdict.flags = c.flags;
				typed_verdict.olen_val = c.olen;
				typed_verdict.crc = c.crc;
			end
			typed_active = 1'b1;
			build_buffer(c);
			send_buffer();
		end
		drain_results();
		typed_active = 1'b0;

		random_budget = TOTAL_ITEMS - items_sent;
		for (int ph = 0; ph < 3; ph++) begin
			drain_results();
			case (ph)
				0: begin
					sender_idle_pct = 11;
					receiver_stall_pct = 45;
					write_config($urandom, 8'($urandom_range(255)), 8'(1 << $urandom_range(7)));
				end
				1: begin
					sender_idle_pct = 45;
					receiver_stall_pct = 11;
					write_config($urandom, 8'hFF, 8'($urandom_range(255)));
				end
				default: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
					write_config(MAGIC_RESET, KNOWN_MASK_RESET, RAW_MASK_RESET);
				end
			endcase
			phase_end = (ph == 2) ? TOTAL_ITEMS : items_sent + random_budget / 3;
			while (items_sent < phase_end) begin
				if ($urandom_range(19) == 0) drain_results();
				build_buffer(random_case());
				// The last buffer of a phase is cut to the item budget and ends early.
				while (buffer_bytes.size() > phase_end - items_sent) begin
					buffer_bytes.delete(buffer_bytes.size() - 1);
				end
				send_buffer();
			end
		end
		drain_results();

		$display("Sent %0d items in %0d header buffers and checked %0d results under three stall mixes.",
			items_accepted, buffers_sent, results_checked);
		$display("Verdicts seen per error code 0 to 6: %0d %0d %0d %0d %0d %0d %0d",
			verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3],
			verdict_tally[4], verdict_tally[5], verdict_tally[6]);
		if (mismatch_count == 0) begin
			$display("huffman_header_checker: match");
		end else begin
			$display("huffman_header_checker: mismatch");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("%0t: timed out with %0d results still outstanding", $time,
			expected_results.size());
		$display("huffman_header_checker: mismatch");
		$finish;
	end

endmodule
